// ===== design/script_token_lexer_macros.svh =====
// ----------------------------------------------------------------------------
// script_token_lexer_macros.svh
// Assertion macros shared by the lexer queue and back modules; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define STL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("script_token_lexer: assertion failed");

// Check that a condition in one cycle implies another in the next.
`define STL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("script_token_lexer: assertion failed");

`else

`define STL_ASSERT(lbl, prop)
`define STL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared widths, token kinds, character codes and result types of the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

  // Field widths
  localparam int POS_W = 20;
  localparam int LEN_W = 16;
  localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Results per byte and queue between front and back
  localparam int SLOTS     = 3;
  localparam int CNT_W     = 2;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef enum logic [3:0] {
    KIND_LABEL    = 4'd0,
    KIND_INVOKE   = 4'd1,
    KIND_EXPR     = 4'd2,
    KIND_SHOWTEXT = 4'd3,
    KIND_SHOWNAME = 4'd4,
    KIND_HEADER   = 4'd5,
    KIND_BEGIN    = 4'd6,
    KIND_ENDBLK   = 4'd7,
    KIND_END      = 4'd8,
    KIND_ERROR    = 4'd9
  } kind_t;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  len;
  } res_t;

  // All results caused by one byte, in order
  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    res_t [SLOTS-1:0]   slot;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return c inside {CH_TAB, CH_CR, CH_LF};
  endfunction

  // Length from begin up to end (exclusive), saturating
  function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W-1:0] end_pos,
                                               input logic [POS_W-1:0] beg_pos);
    logic [POS_W-1:0] d;
    logic [CMP_W-1:0] dw;
    d  = (end_pos >= beg_pos) ? end_pos - beg_pos : '0;
    dw = CMP_W'(d);
    if (dw > CMP_W'(LEN_MAX)) begin
      return LEN_MAX;
    end
    return LEN_W'(dw);
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [POS_W-1:0] s,
                                  input logic [LEN_W-1:0] l);
    res_t r;
    r.kind  = k;
    r.start = s;
    r.len   = l;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/stl_queue.sv =====
// ----------------------------------------------------------------------------
// stl_queue
// Short FIFO of per-byte result bundles between the lexer front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "script_token_lexer_macros.svh"

module stl_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire stl_pkg::bundle_t  push_data,
  input  wire logic              pop,
  output stl_pkg::bundle_t       head,
  output stl_pkg::q_stat_t       stat
);

  stl_pkg::bundle_t                 mem_r [stl_pkg::Q_DEPTH];
  logic [stl_pkg::Q_PTR_W-1:0]      wr_ptr_r;
  logic [stl_pkg::Q_PTR_W-1:0]      rd_ptr_r;
  logic [stl_pkg::Q_CNT_W-1:0]      cnt_r;

  function automatic logic [stl_pkg::Q_PTR_W-1:0] ptr_inc(
      input logic [stl_pkg::Q_PTR_W-1:0] p);
    return (p == stl_pkg::Q_PTR_W'(stl_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Status and head
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == stl_pkg::Q_CNT_W'(stl_pkg::Q_DEPTH));
  assign head       = mem_r[rd_ptr_r];

  // Store beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `STL_ASSERT(a_no_overflow, push |-> !stat.full)
  `STL_ASSERT(a_no_underflow, pop |-> !stat.empty)
  `STL_ASSERT_NEXT(a_push_fills, push && !pop, !stat.empty)

endmodule

`default_nettype wire

// ===== design/stl_front.sv =====
// ----------------------------------------------------------------------------
// stl_front
// Lexer front: takes one text byte per beat, tracks the token state and
// builds the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               in_text_byte,
  input  wire logic                     in_final_byte,
  input  wire stl_pkg::q_stat_t         q_stat,
  output logic                          push,
  output stl_pkg::bundle_t              push_data
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_TEXT,
    M_ST_DIG,
    M_ST_QUOTE,
    M_BE_DIG,
    M_NUM,
    M_HDR_DIG,
    M_BRACKET
  } mode_t;

  mode_t                        mode_r,  mode_nxt;
  logic [stl_pkg::POS_W-1:0]    pos_r,   pos_nxt;
  logic [stl_pkg::POS_W-1:0]    tbeg_r,  tbeg_nxt;
  stl_pkg::kind_t               pk_r,    pk_nxt;
  logic                         inq_r,   inq_nxt;
  logic                         drop_r,  drop_nxt;

  logic                         acc;
  logic [7:0]                   c;
  logic [stl_pkg::POS_W-1:0]    pos_inc;
  logic [stl_pkg::LEN_W-1:0]    incl_old;
  logic [stl_pkg::LEN_W-1:0]    excl_old;
  logic [stl_pkg::LEN_W-1:0]    incl_new;
  stl_pkg::res_t                cand   [4];
  logic [3:0]                   cand_v;
  stl_pkg::bundle_t             bnd;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !in_stall;
  assign c        = in_text_byte;

  // Saturating position and the three possible lengths
  assign pos_inc  = (pos_r == stl_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
  assign incl_old = stl_pkg::sat_len(pos_inc, tbeg_r);
  assign excl_old = stl_pkg::sat_len(pos_r, tbeg_r);
  assign incl_new = stl_pkg::sat_len(pos_inc, pos_r);

  // Classify the byte and collect candidate results
  always_comb begin
    logic                      do_start;
    logic                      started;
    logic [stl_pkg::LEN_W-1:0] incl_f;

    mode_nxt = mode_r;
    pos_nxt  = pos_inc;
    tbeg_nxt = tbeg_r;
    pk_nxt   = pk_r;
    inq_nxt  = inq_r;
    drop_nxt = drop_r;
    do_start = 1'b0;
    started  = 1'b0;
    incl_f   = incl_old;
    cand_v   = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    if (!drop_r) begin
      case (mode_r)
        M_IDLE: begin
          do_start = 1'b1;
        end
        M_TEXT: begin
          if (stl_pkg::is_break(c)) begin
            cand[0]   = stl_pkg::mk_res(pk_r, tbeg_r, excl_old);
            cand_v[0] = 1'b1;
            mode_nxt  = M_IDLE;
          end
        end
        M_ST_DIG: begin
          if (!stl_pkg::is_digit(c)) begin
            mode_nxt = M_ST_QUOTE;
          end
        end
        M_ST_QUOTE: begin
          if (c == stl_pkg::CH_QUOTE) begin
            cand[0]   = stl_pkg::mk_res(stl_pkg::KIND_SHOWTEXT, tbeg_r, incl_old);
            cand_v[0] = 1'b1;
            mode_nxt  = M_IDLE;
          end
        end
        M_BE_DIG: begin
          if (!stl_pkg::is_digit(c)) begin
            cand[0]   = stl_pkg::mk_res(stl_pkg::KIND_ENDBLK, tbeg_r, incl_old);
            cand_v[0] = 1'b1;
            mode_nxt  = M_IDLE;
          end
        end
        M_NUM: begin
          if (stl_pkg::is_digit(c)) begin
            mode_nxt = M_NUM;
          end else if (c == stl_pkg::CH_LPAREN) begin
            mode_nxt = M_BRACKET;
            pk_nxt   = stl_pkg::KIND_INVOKE;
            inq_nxt  = 1'b0;
          end else if (c == stl_pkg::CH_COMMA) begin
            mode_nxt = M_HDR_DIG;
            pk_nxt   = stl_pkg::KIND_HEADER;
          end else begin
            cand[0]   = stl_pkg::mk_res(stl_pkg::KIND_ERROR, tbeg_r, incl_old);
            cand_v[0] = 1'b1;
            drop_nxt  = 1'b1;
            mode_nxt  = M_IDLE;
          end
        end
        M_HDR_DIG: begin
          if (stl_pkg::is_digit(c)) begin
            mode_nxt = M_HDR_DIG;
          end else if (c == stl_pkg::CH_LPAREN) begin
            mode_nxt = M_BRACKET;
            pk_nxt   = stl_pkg::KIND_HEADER;
            inq_nxt  = 1'b0;
          end else begin
            // header ends before this byte; lex the byte afresh
            cand[0]   = stl_pkg::mk_res(stl_pkg::KIND_HEADER, tbeg_r, excl_old);
            cand_v[0] = 1'b1;
            mode_nxt  = M_IDLE;
            do_start  = 1'b1;
          end
        end
        M_BRACKET: begin
          if (inq_r) begin
            if (c == stl_pkg::CH_QUOTE) begin
              inq_nxt = 1'b0;
            end
          end else if (c == stl_pkg::CH_RPAREN) begin
            cand[0]   = stl_pkg::mk_res(pk_r, tbeg_r, incl_old);
            cand_v[0] = 1'b1;
            mode_nxt  = M_IDLE;
          end else if (c == stl_pkg::CH_QUOTE) begin
            inq_nxt = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
        end
      endcase
    end

    // Open a new token on its first byte
    if (do_start && !stl_pkg::is_break(c) && (c != stl_pkg::CH_SPACE)) begin
      started  = 1'b1;
      tbeg_nxt = pos_r;
      inq_nxt  = 1'b0;
      case (c)
        stl_pkg::CH_DOLLAR: begin
          mode_nxt = M_TEXT;
          pk_nxt   = stl_pkg::KIND_LABEL;
        end
        stl_pkg::CH_UNDER, stl_pkg::CH_AT, stl_pkg::CH_COLON: begin
          mode_nxt = M_TEXT;
          pk_nxt   = stl_pkg::KIND_EXPR;
        end
        stl_pkg::CH_HASH: begin
          mode_nxt = M_TEXT;
          pk_nxt   = stl_pkg::KIND_SHOWNAME;
        end
        stl_pkg::CH_AMP: begin
          mode_nxt = M_ST_DIG;
          pk_nxt   = stl_pkg::KIND_SHOWTEXT;
        end
        stl_pkg::CH_LBRACE: begin
          cand[1]   = stl_pkg::mk_res(stl_pkg::KIND_BEGIN, pos_r, incl_new);
          cand_v[1] = 1'b1;
        end
        stl_pkg::CH_RBRACE: begin
          mode_nxt = M_BE_DIG;
          pk_nxt   = stl_pkg::KIND_ENDBLK;
        end
        default: begin
          if (stl_pkg::is_digit(c)) begin
            mode_nxt = M_NUM;
            pk_nxt   = stl_pkg::KIND_INVOKE;
          end else begin
            cand[1]   = stl_pkg::mk_res(stl_pkg::KIND_ERROR, pos_r, incl_new);
            cand_v[1] = 1'b1;
            drop_nxt  = 1'b1;
            mode_nxt  = M_IDLE;
          end
        end
      endcase
    end

    // Close the text on the final byte and return to reset state
    if (in_final_byte) begin
      incl_f = started ? incl_new : incl_old;
      if (!drop_nxt) begin
        case (mode_nxt)
          M_IDLE: begin
            cand_v[2] = 1'b0;
          end
          M_TEXT: begin
            cand[2]   = stl_pkg::mk_res(pk_nxt, tbeg_nxt, incl_f);
            cand_v[2] = 1'b1;
          end
          M_HDR_DIG: begin
            cand[2]   = stl_pkg::mk_res(stl_pkg::KIND_HEADER, tbeg_nxt, incl_f);
            cand_v[2] = 1'b1;
          end
          default: begin
            cand[2]   = stl_pkg::mk_res(stl_pkg::KIND_ERROR, tbeg_nxt, incl_f);
            cand_v[2] = 1'b1;
          end
        endcase
      end
      cand[3]   = stl_pkg::mk_res(stl_pkg::KIND_END, pos_inc, '0);
      cand_v[3] = 1'b1;
      mode_nxt  = M_IDLE;
      pos_nxt   = '0;
      tbeg_nxt  = '0;
      pk_nxt    = stl_pkg::KIND_LABEL;
      inq_nxt   = 1'b0;
      drop_nxt  = 1'b0;
    end
  end

  // Pack candidates into the first free slots
  always_comb begin
    bnd = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (bnd.cnt != stl_pkg::CNT_W'(stl_pkg::SLOTS))) begin
        bnd.slot[bnd.cnt] = cand[i];
        bnd.cnt           = bnd.cnt + 1'b1;
      end
    end
  end

  assign push      = acc && (bnd.cnt != '0);
  assign push_data = bnd;

  // Hold lexer state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      tbeg_r <= '0;
      pk_r   <= stl_pkg::KIND_LABEL;
      inq_r  <= 1'b0;
      drop_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      tbeg_r <= tbeg_nxt;
      pk_r   <= pk_nxt;
      inq_r  <= inq_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/stl_back.sv =====
// ----------------------------------------------------------------------------
// stl_back
// Lexer back: unpacks queued bundles and sends one result beat per cycle
// through the output register while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "script_token_lexer_macros.svh"

module stl_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire stl_pkg::bundle_t            head,
  input  wire stl_pkg::q_stat_t            stat,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [3:0]                       out_token_kind,
  output logic [stl_pkg::POS_W-1:0]        out_token_start,
  output logic [stl_pkg::LEN_W-1:0]        out_token_length,
  output logic                             out_last_of_run
);

  logic                        out_valid_r;
  stl_pkg::res_t               out_res_r;
  logic                        out_last_r;
  logic [stl_pkg::CNT_W-1:0]   idx_r;

  logic                        load;
  logic                        last_slot;

  // Load the next slot whenever the output register frees up
  assign load      = !stat.empty && (!out_valid_r || !out_stall);
  assign last_slot = (idx_r == head.cnt - 1'b1);
  assign pop       = load && last_slot;

  // Hold valid and slot index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= last_slot ? '0 : idx_r + 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= head.slot[idx_r];
      out_last_r <= last_slot;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = out_res_r.kind;
  assign out_token_start  = out_res_r.start;
  assign out_token_length = out_res_r.len;
  assign out_last_of_run  = out_last_r;

  `STL_ASSERT(a_head_nonempty, !stat.empty |-> head.cnt != '0)
  `STL_ASSERT(a_idx_below_cnt, !stat.empty |-> idx_r < head.cnt)
  `STL_ASSERT_NEXT(a_load_shows, load, out_valid_r)

endmodule

`default_nettype wire

// ===== design/script_token_lexer.sv =====
// ----------------------------------------------------------------------------
// script_token_lexer
// Byte-serial tokenizer for script text.
// ----------------------------------------------------------------------------
// Input channel: one text byte per beat (in_text_byte), with in_final_byte
// set on the last byte of a text. Result channel: one token per beat with
// kind, start offset, saturating length and last_of_run, which marks the
// final result caused by one input byte. An End token follows every text.
// Both channels accept a beat when valid is high and stall is low.
// Throughput: one input byte per cycle while results drain; a byte that
// causes k results sends them as k output beats (k is at most 3).
// The accepting edge writes a byte's result bundle into the queue; a later
// edge loads its first result into the output register once that register
// is free; further results follow one per cycle while out_stall is low.
// A four-entry queue of result bundles sits between the lexer front and
// the output back; in_stall rises only when that queue is full, so a
// stalled receiver backs up the queue before it stops the input.
// Reset (rst_n low, synchronous) empties the queue and output register and
// puts the lexer in its idle state at offset zero.
// ----------------------------------------------------------------------------
`default_nettype none

module script_token_lexer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_text_byte,
  input  wire logic                        in_final_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [3:0]                       out_token_kind,
  output logic [stl_pkg::POS_W-1:0]        out_token_start,
  output logic [stl_pkg::LEN_W-1:0]        out_token_length,
  output logic                             out_last_of_run
);

  logic               push;
  stl_pkg::bundle_t   push_data;
  logic               pop;
  stl_pkg::bundle_t   head;
  stl_pkg::q_stat_t   q_stat;

  // Classify bytes
  stl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  // Buffer result bundles
  stl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Send results
  stl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .stat             (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

`default_nettype wire
